>>> rtl/kct_pkg.sv
// shared constants and types for the keyed client table
package kct_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int HANDLE_W    = 16;
    localparam int USED_W      = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

endpackage

>>> rtl/kct_entry_ram.sv
// entry memory: one write port, one read port with registered read data
module kct_entry_ram (
    input  logic            clk,
    input  kct_pkg::ram_wr_t wr,
    input  kct_pkg::ram_rd_t rd,
    output kct_pkg::entry_t  rdata
);
    import kct_pkg::*;

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rdata <= mem[rd.addr];
        end
    end

endmodule

>>> rtl/keyed_client_table_core.sv
// keyed client table: dense unordered key/handle table with linear search
//
//  channel  | direction | tdata (low bit up)             | tuser
//  s_*      | in        | client_key, client_handle      | operation
//  m_*      | out       | found_handle, entries_used, pad| status
//
// an operation that needs a search scans the stored keys one per cycle through the
// entry ram read port, and a remove that moves the last entry into the freed slot
// then reads that entry and writes it into the slot. one operation is in flight at a time.
// s_tready is high whenever the core is idle, also while a result waits on m_*.
// reset clears the entry count, the state and the valid flags; the entry memory is not cleared.
module keyed_client_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // client_key[31:0], client_handle[47:32]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // found_handle[15:0], entries_used[22:16], zero[23]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import kct_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_MOVE_RD = 5'b00100,
        S_MOVE_WR = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    op_t                 op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    status_t             status_reg, status_next;
    logic [HANDLE_W-1:0] found_reg, found_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [HANDLE_W-1:0] m_found_reg, m_found_next;
    logic [USED_W-1:0]   m_used_reg, m_used_next;

    ram_wr_t ram_wr;
    ram_rd_t ram_rd;
    entry_t  ram_rdata;
    logic    hit;
    logic    last;

    kct_entry_ram u_entry_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_used_reg, m_found_reg};
    assign m_tuser  = m_status_reg;

    // compare the entry read in the previous cycle
    assign hit  = pend_valid_reg && (ram_rdata.key == key_reg);
    assign last = pend_valid_reg && (CNT_W'(pend_idx_reg) == count_reg - CNT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        slot_next       = slot_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        m_used_next     = m_used_reg;
        ram_wr          = '0;
        ram_rd          = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = op_t'(s_tuser);
                    key_next        = s_tdata[KEY_W-1:0];
                    handle_next     = s_tdata[KEY_W+HANDLE_W-1:KEY_W];
                    issue_next      = '0;
                    pend_valid_next = 1'b0;
                    status_next     = ST_OK;
                    found_next      = '0;
                    state_next      = S_DONE;
                    case (op_t'(s_tuser))
                        OP_INSERT:
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_wr.we   = 1'b1;
                                ram_wr.addr = '0;
                                ram_wr.data = {s_tdata[KEY_W+HANDLE_W-1:KEY_W],
                                               s_tdata[KEY_W-1:0]};
                                count_next  = CNT_W'(1);
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_LOOKUP, OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    ram_rd.re       = 1'b1;
                    ram_rd.addr     = issue_reg[IDX_W-1:0];
                    issue_next      = issue_reg + CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end

                if (hit)
                begin
                    pend_valid_next = 1'b0;
                    slot_next       = pend_idx_reg;
                    state_next      = S_DONE;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            status_next = ST_DUP;
                        end
                        OP_LOOKUP:
                        begin
                            found_next = ram_rdata.handle;
                        end
                        OP_REMOVE:
                        begin
                            found_next = ram_rdata.handle;
                            count_next = count_reg - CNT_W'(1);
                            // removing the last entry leaves nothing to move
                            if (!last)
                            begin
                                state_next = S_MOVE_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
                else if (last)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_DONE;
                    if (op_reg == OP_INSERT)
                    begin
                        ram_wr.we   = 1'b1;
                        ram_wr.addr = count_reg[IDX_W-1:0];
                        ram_wr.data = {handle_reg, key_reg};
                        count_next  = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_MISSING;
                    end
                end
            end

            S_MOVE_RD:
            begin
                // count already dropped, so it indexes the old last entry
                ram_rd.re   = 1'b1;
                ram_rd.addr = count_reg[IDX_W-1:0];
                state_next  = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = slot_reg;
                ram_wr.data = ram_rdata;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = found_reg;
                    m_used_next   = USED_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        handle_reg   <= handle_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_used_reg   <= m_used_next;
    end

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the keyed client table core: directed rows, a fill to capacity, then random traffic
`timescale 1ns / 1ps

module tb_top;
    import kct_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         TAIL_CYCLES = 2 * TABLE_DEPTH + 20;
    localparam int         PHASE_ITEMS = 265;
    localparam int         SEG_LEN     = 128;

    localparam int MODE_FILL  = 0;
    localparam int MODE_MIX   = 1;
    localparam int MODE_DRAIN = 2;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] found;
        logic [USED_W-1:0]   used;
    } table_result_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic                typed;
        status_t             status;
        logic [HANDLE_W-1:0] found;
        logic [USED_W-1:0]   used;
    } stim_row_t;

    // rows with typed = 0 are checked against the predictor only
    localparam stim_row_t DIRECTED_ROWS [23] = '{
        '{OP_LOOKUP, 32'h1234_5678, 16'h0000, 1'b1, ST_MISSING, 16'h0000, 7'd0},
        '{OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b1, ST_MISSING, 16'h0000, 7'd0},
        '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_OK,      16'h0000, 7'd0},
        '{OP_INSERT, 32'h0000_0000, 16'h0000, 1'b1, ST_OK,      16'h0000, 7'd1},
        '{OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_OK,      16'h0000, 7'd2},
        '{OP_INSERT, 32'h0000_0000, 16'h1234, 1'b1, ST_DUP,     16'h0000, 7'd2},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 16'h5555, 1'b1, ST_OK,      16'hFFFF, 7'd2},
        '{OP_LOOKUP, 32'h0000_0000, 16'hAAAA, 1'b1, ST_OK,      16'h0000, 7'd2},
        '{OP_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b1, ST_OK,      16'hFFFF, 7'd1},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1'b1, ST_MISSING, 16'h0000, 7'd1},
        '{OP_INSERT, 32'h8000_0001, 16'h8001, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_INSERT, 32'h0000_0002, 16'h7FFE, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_INSERT, 32'hDEAD_BEEF, 16'hA5A5, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_REMOVE, 32'h0000_0000, 16'hFFFF, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_LOOKUP, 32'hDEAD_BEEF, 16'h0000, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_INSERT, 32'hDEAD_BEEF, 16'h1111, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_REMOVE, 32'h8000_0001, 16'h0000, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_UNUSED, 32'h8000_0001, 16'h8001, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_LOOKUP, 32'h0000_0002, 16'h0000, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_REMOVE, 32'h0000_0002, 16'h0000, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_REMOVE, 32'hDEAD_BEEF, 16'h0000, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_INSERT, 32'h5555_5555, 16'hAAAA, 1'b0, ST_OK,      16'h0000, 7'd0},
        '{OP_LOOKUP, 32'h5555_5555, 16'h0000, 1'b0, ST_OK,      16'h0000, 7'd0}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // client_key[31:0], client_handle[47:32]
    logic [1:0]  s_tuser  = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // found_handle[15:0], entries_used[22:16], zero[23]
    logic [1:0]  m_tuser;         // status[1:0]

    // predictor copy of the table
    logic [KEY_W-1:0]    tbl_keys    [TABLE_DEPTH];
    logic [HANDLE_W-1:0] tbl_handles [TABLE_DEPTH];
    int                  tbl_count = 0;

    table_result_t pending_results [$];
    int            err_cnt       = 0;
    int            cycle_cnt     = 0;
    int            snd_idle_pct  = 0;
    int            rcv_stall_pct = 0;

    keyed_client_table_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // linear search for the first match, returns tbl_count on a miss
    function automatic int find_entry(input logic [KEY_W-1:0] key);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_keys[i] == key)
                return i;
        end
        return tbl_count;
    endfunction

    function automatic table_result_t predict_table_op(input logic [1:0] op,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [HANDLE_W-1:0] handle);
        table_result_t res;
        int            slot;
        res.status = ST_OK;
        res.found  = '0;
        if (op == OP_INSERT)
        begin
            if (tbl_count >= TABLE_DEPTH)
                res.status = ST_FULL;
            else if (find_entry(key) < tbl_count)
                res.status = ST_DUP;
            else
            begin
                tbl_keys[tbl_count]    = key;
                tbl_handles[tbl_count] = handle;
                tbl_count++;
            end
        end
        else if (op == OP_LOOKUP || op == OP_REMOVE)
        begin
            slot = find_entry(key);
            if (slot >= tbl_count)
                res.status = ST_MISSING;
            else
            begin
                res.found = tbl_handles[slot];
                if (op == OP_REMOVE)
                begin
                    // last entry fills the hole so the table stays dense
                    tbl_count--;
                    tbl_keys[slot]    = tbl_keys[tbl_count];
                    tbl_handles[slot] = tbl_handles[tbl_count];
                end
            end
        end
        res.used = tbl_count[USED_W-1:0];
        return res;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                             input logic [HANDLE_W-1:0] handle, input logic typed,
                             input table_result_t typed_res);
        table_result_t res;
        s_tdata  <= {handle, key};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        res = predict_table_op(op, key, handle);
        pending_results.push_back(typed ? typed_res : res);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_random(input int mode, output logic [1:0] op);
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        int                  r;
        int                  sel;
        int                  hit_pct;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  op = (r < 88) ? OP_INSERT : (r < 94) ? OP_LOOKUP : OP_REMOVE;
            MODE_DRAIN: op = (r < 15) ? OP_INSERT : (r < 35) ? OP_LOOKUP : OP_REMOVE;
            default:    op = (r < 40) ? OP_INSERT : (r < 70) ? OP_LOOKUP : OP_REMOVE;
        endcase
        if ($urandom_range(0, 99) < 3)
            op = OP_UNUSED;
        hit_pct = (mode == MODE_FILL) ? 10 : 55;
        sel     = $urandom_range(0, 99);
        if (sel < hit_pct && tbl_count > 0)
            key = tbl_keys[$urandom_range(0, tbl_count - 1)];
        else if (sel < hit_pct + 25)
            key = $urandom_range(0, 95);
        else
            key = $urandom;
        handle = 16'($urandom);
        send_item(op, key, handle, 1'b0, '0);
    endtask

    // hold the sender off until every pending result has been returned
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result();
        table_result_t exp_r;
        if (pending_results.size() == 0)
        begin
            $error("result with nothing pending: tuser %0d tdata %h", m_tuser, m_tdata);
            err_cnt++;
        end
        else
        begin
            exp_r = pending_results.pop_front();
            if (m_tuser !== exp_r.status)
            begin
                $error("status expected %0d actual %0d", exp_r.status, m_tuser);
                err_cnt++;
            end
            if (m_tdata[15:0] !== exp_r.found)
            begin
                $error("found_handle expected %h actual %h", exp_r.found, m_tdata[15:0]);
                err_cnt++;
            end
            if (m_tdata[22:16] !== exp_r.used)
            begin
                $error("entries_used expected %0d actual %0d", exp_r.used, m_tdata[22:16]);
                err_cnt++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        table_result_t       typed_res;
        logic [1:0]          op;
        logic [KEY_W-1:0]    last_key;
        int                  n;
        int                  seg;
        int                  mode;
        int                  idle_tab  [4];
        int                  stall_tab [4];
        idle_tab  = '{0, 73, 0, 7};
        stall_tab = '{0, 0, 73, 7};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            typed_res.status = DIRECTED_ROWS[i].status;
            typed_res.found  = DIRECTED_ROWS[i].found;
            typed_res.used   = DIRECTED_ROWS[i].used;
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].handle,
                      DIRECTED_ROWS[i].typed, typed_res);
        end

        // fill to capacity, then hit the full case, also with a key already present
        last_key = '0;
        while (tbl_count < TABLE_DEPTH)
        begin
            last_key = $urandom;
            send_item(OP_INSERT, last_key, 16'($urandom), 1'b0, '0);
        end
        send_item(OP_INSERT, $urandom, 16'($urandom), 1'b0, '0);
        send_item(OP_INSERT, last_key, 16'hFFFF, 1'b0, '0);
        send_item(OP_LOOKUP, last_key, 16'h0000, 1'b0, '0);
        send_item(OP_REMOVE, tbl_keys[0], 16'h0000, 1'b0, '0);
        wait_results_done();

        for (int p = 0; p < 4; p++)
        begin
            snd_idle_pct  = idle_tab[p];
            rcv_stall_pct = stall_tab[p];
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                seg  = (n / SEG_LEN + p) % 4;
                mode = (seg == 0) ? MODE_FILL : (seg == 2) ? MODE_DRAIN : MODE_MIX;
                send_random(mode, op);
                if (op != OP_UNUSED)
                    n++;
            end
            wait_results_done();
        end

        rcv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
